[rtl/spab_pkg.sv]
// Shared types and constants for the splat alpha brush texel pipeline.
// No dependencies; used by every module under rtl/.
package spab_pkg;

   // Register indexes of the configuration port
   typedef enum logic [2:0] {
      REG_CENTER_U       = 3'd0,
      REG_CENTER_V       = 3'd1,
      REG_TERRAIN_WIDTH  = 3'd2,
      REG_TERRAIN_HEIGHT = 3'd3,
      REG_INNER_RADIUS   = 3'd4,
      REG_OUTER_RADIUS   = 3'd5,
      REG_BRUSH_ALPHA    = 3'd6,
      REG_BRUSH_MODE     = 3'd7
   } reg_type;

   // Region codes on the result channel
   localparam logic [1:0] REGION_OUT   = 2'd0;
   localparam logic [1:0] REGION_INNER = 2'd1;
   localparam logic [1:0] REGION_RING  = 2'd2;

   typedef struct packed {
      logic signed [17:0] center_u;
      logic signed [17:0] center_v;
      logic [15:0]        terrain_width;
      logic [15:0]        terrain_height;
      logic [15:0]        inner_radius;
      logic [15:0]        outer_radius;
      logic [7:0]         brush_alpha;
      logic [2:0]         brush_mode;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      center_u:       18'sd0,
      center_v:       18'sd0,
      terrain_width:  16'd4096,
      terrain_height: 16'd4096,
      inner_radius:   16'd80,
      outer_radius:   16'd160,
      brush_alpha:    8'd255,
      brush_mode:     3'd0
   };

   // Texel word and region flags carried alongside the arithmetic
   typedef struct packed {
      logic [31:0] word;
      logic        inner;
      logic        ring;
   } side_type;

endpackage

[rtl/spab_dist.sv]
// Distance front end: normalized position, scaled axis distances, squared length
// and inner/ring classification over five stages. Depends on spab_pkg.
module spab_dist #(
   parameter int MAP_WIDTH  = 256,
   parameter int MAP_HEIGHT = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  spab_pkg::cfg_type   cfg,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [7:0]          in_x,
   input  logic [7:0]          in_y,
   input  logic [31:0]         in_word,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [31:0]         out_n,
   output spab_pkg::side_type  out_side
);

   localparam int NS    = 5;
   localparam int DIV_U = (MAP_WIDTH  < 2) ? 1 : MAP_WIDTH  - 1;
   localparam int DIV_V = (MAP_HEIGHT < 2) ? 1 : MAP_HEIGHT - 1;

   logic [NS-1:0]  v_ff;
   logic [NS-1:0]  en;
   logic [31:0]    word_ff [NS];

   logic [23:0]    au_tab [256];
   logic [23:0]    av_tab [256];

   logic signed [25:0] du, dv;
   logic [24:0]    absu_in, absv_in;
   logic [24:0]    absu_ff, absv_ff;
   logic [40:0]    pu, pv;
   logic [24:0]    ru_ff, rv_ff;
   logic [49:0]    squ_ff, sqv_ff;
   logic [50:0]    sum_ff;
   logic [33:0]    inner_sq_ff, outer_sq_ff;
   logic [16:0]    inner_p1, outer_p1;
   logic [31:0]    n_ff;
   logic           inner_ff, ring_ff;
   logic           inner_in, ring_in;

   // Normalized coordinate tables, worked out at elaboration
   for (genvar i = 0; i < 256; i++) begin : g_tab
      localparam longint AU = (longint'(i) * 65536) / DIV_U;
      localparam longint AV = (longint'(i) * 65536) / DIV_V;
      assign au_tab[i] = 24'(AU);
      assign av_tab[i] = 24'(AV);
   end

   // Stall chain: a stage loads when empty or when the next one loads
   always_comb begin
      en[NS-1] = !v_ff[NS-1] || out_ready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end
   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= in_valid;
         for (int k = 1; k < NS; k++) begin
            if (en[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   // Carry the texel word
   always_ff @(posedge clock) begin
      if (en[0]) word_ff[0] <= in_word;
      for (int k = 1; k < NS; k++) begin
         if (en[k]) word_ff[k] <= word_ff[k-1];
      end
   end

   // Stage 1: offset from the center, absolute value
   always_comb begin
      du = $signed({2'b00, au_tab[in_x]}) - 26'(cfg.center_u);
      dv = $signed({2'b00, av_tab[in_y]}) - 26'(cfg.center_v);
      absu_in = du[25] ? 25'(-du) : du[24:0];
      absv_in = dv[25] ? 25'(-dv) : dv[24:0];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         absu_ff <= absu_in;
         absv_ff <= absv_in;
      end
   end

   // Stage 2: scale by the terrain extent, unsigned integer
   assign pu = absu_ff * cfg.terrain_width;
   assign pv = absv_ff * cfg.terrain_height;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         ru_ff <= pu[40:16];
         rv_ff <= pv[40:16];
      end
   end

   // Stage 3: square each axis
   always_ff @(posedge clock) begin
      if (en[2]) begin
         squ_ff <= ru_ff * ru_ff;
         sqv_ff <= rv_ff * rv_ff;
      end
   end

   // Stage 4: squared length
   always_ff @(posedge clock) begin
      if (en[3]) sum_ff <= {1'b0, squ_ff} + {1'b0, sqv_ff};
   end

   // Radius thresholds: len <= r exactly when sum < (r+1)^2
   assign inner_p1 = {1'b0, cfg.inner_radius} + 17'd1;
   assign outer_p1 = {1'b0, cfg.outer_radius} + 17'd1;

   always_ff @(posedge clock) begin
      inner_sq_ff <= inner_p1 * inner_p1;
      outer_sq_ff <= outer_p1 * outer_p1;
   end

   // Stage 5: classify
   assign inner_in = sum_ff < {17'd0, inner_sq_ff};
   assign ring_in  = !inner_in && (sum_ff < {17'd0, outer_sq_ff});

   always_ff @(posedge clock) begin
      if (en[4]) begin
         n_ff     <= sum_ff[31:0];
         inner_ff <= inner_in;
         ring_ff  <= ring_in;
      end
   end

   assign out_valid      = v_ff[NS-1];
   assign out_n          = n_ff;
   assign out_side.word  = word_ff[NS-1];
   assign out_side.inner = inner_ff;
   assign out_side.ring  = ring_ff;

endmodule

[rtl/spab_sqrt.sv]
// Pipelined integer square root of a 32-bit value, two result bits per stage.
// Depends on spab_pkg for the carried side data.
module spab_sqrt (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [31:0]         in_n,
   input  spab_pkg::side_type  in_side,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [15:0]         out_root,
   output spab_pkg::side_type  out_side
);

   localparam int NS = 8;

   typedef struct packed {
      logic [17:0] rem;
      logic [15:0] root;
      logic [31:0] n;
   } sq_type;

   logic [NS-1:0]      v_ff;
   logic [NS-1:0]      en;
   sq_type             st_ff [NS];
   sq_type             st_in [NS];
   spab_pkg::side_type side_ff [NS];

   // One restoring step: bring down two bits, try 4*root+1
   function automatic sq_type sq_step(input sq_type s);
      logic [19:0] t;
      logic [19:0] trial;
      sq_type      r;
      t     = {s.rem, s.n[31:30]};
      trial = {2'b00, s.root, 2'b01};
      r.n   = {s.n[29:0], 2'b00};
      if (t >= trial) begin
         r.rem  = 18'(t - trial);
         r.root = {s.root[14:0], 1'b1};
      end else begin
         r.rem  = t[17:0];
         r.root = {s.root[14:0], 1'b0};
      end
      return r;
   endfunction

   always_comb begin
      en[NS-1] = !v_ff[NS-1] || out_ready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end
   assign in_ready = en[0];

   // Two steps per stage
   always_comb begin
      st_in[0] = sq_step(sq_step('{rem: 18'd0, root: 16'd0, n: in_n}));
      for (int k = 1; k < NS; k++) begin
         st_in[k] = sq_step(sq_step(st_ff[k-1]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= in_valid;
         for (int k = 1; k < NS; k++) begin
            if (en[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         st_ff[0]   <= st_in[0];
         side_ff[0] <= in_side;
      end
      for (int k = 1; k < NS; k++) begin
         if (en[k]) begin
            st_ff[k]   <= st_in[k];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_root  = st_ff[NS-1].root;
   assign out_side  = side_ff[NS-1];

endmodule

[rtl/spab_div.sv]
// Falloff color: alpha*(outer-len) divided by (outer-inner), eight quotient bits
// resolved two per stage after a product stage. Depends on spab_pkg.
module spab_div (
   input  logic                clock,
   input  logic                reset,
   input  spab_pkg::cfg_type   cfg,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [15:0]         in_len,
   input  spab_pkg::side_type  in_side,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [7:0]          out_q,
   output spab_pkg::side_type  out_side
);

   localparam int NS = 5;

   logic [NS-1:0]      v_ff;
   logic [NS-1:0]      en;
   logic [23:0]        rem_ff [NS];
   logic [7:0]         q_ff   [NS];
   logic [23:0]        rem_in [NS];
   logic [7:0]         q_in   [NS];
   spab_pkg::side_type side_ff [NS];
   logic [15:0]        den_ff;
   logic [15:0]        span;

   // Quotient is below 256 since the remainder starts below den*256
   function automatic logic [31:0] div_step(input logic [23:0] rem, input logic [7:0] q,
                                            input logic [15:0] den, input int bitpos);
      logic [23:0] d;
      logic [23:0] r;
      logic [7:0]  qq;
      d  = {8'd0, den} << bitpos;
      r  = rem;
      qq = q;
      if (rem >= d) begin
         r  = rem - d;
         qq = q | (8'd1 << bitpos);
      end
      return {r, qq};
   endfunction

   always_ff @(posedge clock) begin
      den_ff <= cfg.outer_radius - cfg.inner_radius;
   end

   assign span = cfg.outer_radius - in_len;

   always_comb begin
      en[NS-1] = !v_ff[NS-1] || out_ready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end
   assign in_ready = en[0];

   // Stage 0 forms the dividend, stage k resolves bits 9-2k and 8-2k
   always_comb begin
      logic [31:0] a;
      logic [31:0] b;
      rem_in[0] = cfg.brush_alpha * span;
      q_in[0]   = 8'd0;
      for (int k = 1; k < NS; k++) begin
         a         = div_step(rem_ff[k-1], q_ff[k-1], den_ff, 9 - 2 * k);
         b         = div_step(a[31:8], a[7:0], den_ff, 8 - 2 * k);
         rem_in[k] = b[31:8];
         q_in[k]   = b[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= in_valid;
         for (int k = 1; k < NS; k++) begin
            if (en[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rem_ff[0]  <= rem_in[0];
         q_ff[0]    <= q_in[0];
         side_ff[0] <= in_side;
      end
      for (int k = 1; k < NS; k++) begin
         if (en[k]) begin
            rem_ff[k]  <= rem_in[k];
            q_ff[k]    <= q_in[k];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_q     = q_ff[NS-1];
   assign out_side  = side_ff[NS-1];

endmodule

[rtl/splat_alpha_brush_texel.sv]
// Splat alpha brush applied to one texel word per cycle. The block takes one
// texel per clock while the result side does not stall and passes it through nineteen
// register stages: five distance stages (position, axis scale, squares, sum, radius
// compare), eight square root stages at two bits each, five falloff division
// stages, and the output word register. A stall on the result side holds the
// pipeline without loss, and empty stages keep filling while a result waits. The
// csr_ registers must be written only while no texel is in flight; the block
// itself does not enforce this.
module splat_alpha_brush_texel #(
   parameter int MAP_WIDTH  = 256,
   parameter int MAP_HEIGHT = 256
) (
   input  logic        clock,
   input  logic        reset,
   // texel input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // texel_x[7:0], texel_y[15:8], old_pixel[47:16]
   // result output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // new_pixel[31:0]
   output logic [2:0]  rsp_tuser,   // region[1:0], changed[2]
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   spab_pkg::cfg_type  cfg_ff;
   spab_pkg::reg_type  csr_idx;
   logic               csr_wr;

   logic               d_valid, d_ready;
   logic [31:0]        d_n;
   spab_pkg::side_type d_side;
   logic               s_valid, s_ready;
   logic [15:0]        s_root;
   spab_pkg::side_type s_side;
   logic               q_valid, q_ready;
   logic [7:0]         q_val;
   spab_pkg::side_type q_side;

   logic               rsp_tvalid_ff;
   logic [31:0]        pixel_ff, pixel_in;
   logic [1:0]         region_ff, region_in;
   logic               changed_ff, changed_in;

   logic               erase;
   logic [4:0]         sh;
   logic [7:0]         dest;
   logic [7:0]         color;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_idx    = spab_pkg::reg_type'(csr_paddr[4:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= spab_pkg::CFG_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            spab_pkg::REG_CENTER_U:       cfg_ff.center_u       <= csr_pwdata[17:0];
            spab_pkg::REG_CENTER_V:       cfg_ff.center_v       <= csr_pwdata[17:0];
            spab_pkg::REG_TERRAIN_WIDTH:  cfg_ff.terrain_width  <= csr_pwdata[15:0];
            spab_pkg::REG_TERRAIN_HEIGHT: cfg_ff.terrain_height <= csr_pwdata[15:0];
            spab_pkg::REG_INNER_RADIUS:   cfg_ff.inner_radius   <= csr_pwdata[15:0];
            spab_pkg::REG_OUTER_RADIUS:   cfg_ff.outer_radius   <= csr_pwdata[15:0];
            spab_pkg::REG_BRUSH_ALPHA:    cfg_ff.brush_alpha    <= csr_pwdata[7:0];
            spab_pkg::REG_BRUSH_MODE:     cfg_ff.brush_mode     <= csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         spab_pkg::REG_CENTER_U:       csr_prdata = 32'(cfg_ff.center_u);
         spab_pkg::REG_CENTER_V:       csr_prdata = 32'(cfg_ff.center_v);
         spab_pkg::REG_TERRAIN_WIDTH:  csr_prdata = {16'd0, cfg_ff.terrain_width};
         spab_pkg::REG_TERRAIN_HEIGHT: csr_prdata = {16'd0, cfg_ff.terrain_height};
         spab_pkg::REG_INNER_RADIUS:   csr_prdata = {16'd0, cfg_ff.inner_radius};
         spab_pkg::REG_OUTER_RADIUS:   csr_prdata = {16'd0, cfg_ff.outer_radius};
         spab_pkg::REG_BRUSH_ALPHA:    csr_prdata = {24'd0, cfg_ff.brush_alpha};
         spab_pkg::REG_BRUSH_MODE:     csr_prdata = {29'd0, cfg_ff.brush_mode};
         default:                      csr_prdata = 32'd0;
      endcase
   end

   // Distance and classification
   spab_dist #(
      .MAP_WIDTH  (MAP_WIDTH),
      .MAP_HEIGHT (MAP_HEIGHT)
   ) u_dist (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_x      (req_tdata[7:0]),
      .in_y      (req_tdata[15:8]),
      .in_word   (req_tdata[47:16]),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .out_n     (d_n),
      .out_side  (d_side)
   );

   // Length in the ring
   spab_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid),
      .in_ready  (d_ready),
      .in_n      (d_n),
      .in_side   (d_side),
      .out_valid (s_valid),
      .out_ready (s_ready),
      .out_root  (s_root),
      .out_side  (s_side)
   );

   // Linear falloff
   spab_div u_div (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (s_valid),
      .in_ready  (s_ready),
      .in_len    (s_root),
      .in_side   (s_side),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_q     (q_val),
      .out_side  (q_side)
   );

   // Blend the selected channel; channel c sits at bits 8*(3-c)+7 down
   assign erase = cfg_ff.brush_mode[2];
   assign sh    = {2'd3 - cfg_ff.brush_mode[1:0], 3'b000};
   assign dest  = 8'(q_side.word >> sh);

   always_comb begin
      color      = 8'd0;
      region_in  = spab_pkg::REGION_OUT;
      changed_in = 1'b0;
      if (q_side.inner) begin
         color      = erase ? 8'd255 - cfg_ff.brush_alpha : cfg_ff.brush_alpha;
         region_in  = spab_pkg::REGION_INNER;
         changed_in = 1'b1;
      end else if (q_side.ring) begin
         color      = erase ? 8'd255 - q_val : q_val;
         region_in  = spab_pkg::REGION_RING;
         changed_in = erase ? (color < dest) : (color > dest);
      end
      pixel_in = changed_in ?
                 ((q_side.word & ~(32'hFF << sh)) | ({24'd0, color} << sh)) :
                 q_side.word;
   end

   // Output word register
   assign q_ready = !rsp_tvalid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (q_ready) begin
         rsp_tvalid_ff <= q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (q_ready) begin
         pixel_ff   <= pixel_in;
         region_ff  <= region_in;
         changed_ff <= changed_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = pixel_ff;
   assign rsp_tuser  = {changed_ff, region_ff};

`ifndef SYNTHESIS
   a_region_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[1:0] == spab_pkg::REGION_OUT ||
                      rsp_tuser[1:0] == spab_pkg::REGION_INNER ||
                      rsp_tuser[1:0] == spab_pkg::REGION_RING))
      else $error("result region code out of range");

   a_inner_writes: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1:0] == spab_pkg::REGION_INNER) |-> rsp_tuser[2])
      else $error("inner disc texel not written");

   a_outside_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1:0] == spab_pkg::REGION_OUT) |-> !rsp_tuser[2])
      else $error("texel outside brush marked changed");
`endif

endmodule

[bench/testbench.sv]
// Self-checking bench for the splat alpha brush texel pipeline.
// Depends on rtl/spab_pkg.sv and rtl/splat_alpha_brush_texel.sv.
`timescale 1ns / 100ps

module testbench;

   localparam int MAP_W = 256;
   localparam int MAP_H = 256;
   localparam int LATENCY = 19;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   typedef struct packed {
      logic [31:0] word;
      logic [1:0]  region;
      logic        changed;
   } texel_result_type;

   spab_pkg::cfg_type brush;
   texel_result_type  pending_texels[$];
   int                mismatches = 0;
   int                words_checked = 0;
   int                words_sent = 0;
   bit                rsp_stall_off = 1'b0;

   splat_alpha_brush_texel #(.MAP_WIDTH(MAP_W), .MAP_HEIGHT(MAP_H)) u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // scaled world distance along one axis, unsigned integer
   function automatic longint unsigned axis_span(int pos, int map_size, longint ctr,
                                                 longint unsigned extent);
      longint div, a, d;
      div = (map_size - 1 < 1) ? 1 : map_size - 1;
      a = (longint'(pos) * 65536) / div;
      d = a - ctr;
      if (d < 0) d = -d;
      return (longint'(d) * extent) >> 16;
   endfunction

   function automatic longint unsigned int_root(longint unsigned n);
      longint unsigned root, b;
      root = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= root + b) begin
            n -= root + b;
            root = (root >> 1) + b;
         end else begin
            root >>= 1;
         end
         b >>= 2;
      end
      return root;
   endfunction

   function automatic texel_result_type paint_texel(logic [7:0] tx, logic [7:0] ty,
                                                    logic [31:0] word);
      texel_result_type r;
      longint unsigned ru, rv, len, color, dest;
      int shift;
      bit erase;
      logic [31:0] keep;
      ru = axis_span(int'(tx), MAP_W, longint'(brush.center_u),
                     64'(brush.terrain_width));
      rv = axis_span(int'(ty), MAP_H, longint'(brush.center_v),
                     64'(brush.terrain_height));
      len = int_root(ru * ru + rv * rv);
      shift = 24 - 8 * brush.brush_mode[1:0];
      erase = brush.brush_mode[2];
      keep = word & ~(32'hFF << shift);
      r.word = word;
      r.region = spab_pkg::REGION_OUT;
      r.changed = 1'b0;
      if (len <= brush.inner_radius) begin
         r.region = spab_pkg::REGION_INNER;
         color = erase ? 255 - brush.brush_alpha : brush.brush_alpha;
         r.word = keep | (32'(color) << shift);
         r.changed = 1'b1;
      end else if (len <= brush.outer_radius) begin
         dest = (word >> shift) & 8'hFF;
         r.region = spab_pkg::REGION_RING;
         color = brush.brush_alpha * (brush.outer_radius - len)
                 / (brush.outer_radius - brush.inner_radius);
         if (erase) color = 255 - color;
         if ((erase && color < dest) || (!erase && color > dest)) begin
            r.word = keep | (32'(color & 8'hFF) << shift);
            r.changed = 1'b1;
         end
      end
      return r;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic write_reg(spab_pkg::reg_type idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 5'(idx) << 2;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         spab_pkg::REG_CENTER_U:       brush.center_u = value[17:0];
         spab_pkg::REG_CENTER_V:       brush.center_v = value[17:0];
         spab_pkg::REG_TERRAIN_WIDTH:  brush.terrain_width = value[15:0];
         spab_pkg::REG_TERRAIN_HEIGHT: brush.terrain_height = value[15:0];
         spab_pkg::REG_INNER_RADIUS:   brush.inner_radius = value[15:0];
         spab_pkg::REG_OUTER_RADIUS:   brush.outer_radius = value[15:0];
         spab_pkg::REG_BRUSH_ALPHA:    brush.brush_alpha = value[7:0];
         spab_pkg::REG_BRUSH_MODE:     brush.brush_mode = value[2:0];
         default: ;
      endcase
   endtask

   task automatic set_brush(spab_pkg::cfg_type c);
      write_reg(spab_pkg::REG_CENTER_U, 32'(c.center_u));
      write_reg(spab_pkg::REG_CENTER_V, 32'(c.center_v));
      write_reg(spab_pkg::REG_TERRAIN_WIDTH, 32'(c.terrain_width));
      write_reg(spab_pkg::REG_TERRAIN_HEIGHT, 32'(c.terrain_height));
      write_reg(spab_pkg::REG_INNER_RADIUS, 32'(c.inner_radius));
      write_reg(spab_pkg::REG_OUTER_RADIUS, 32'(c.outer_radius));
      write_reg(spab_pkg::REG_BRUSH_ALPHA, 32'(c.brush_alpha));
      write_reg(spab_pkg::REG_BRUSH_MODE, 32'(c.brush_mode));
   endtask

   // send one texel word; valid stays high across back-to-back words
   task automatic send_texel(logic [7:0] tx, logic [7:0] ty, logic [31:0] word,
                             bit allow_gap = 1);
      int g;
      g = allow_gap ? gap_len() : 0;
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {word, ty, tx};
      pending_texels.insert(pending_texels.size(), paint_texel(tx, ty, word));
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_texels.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // uniformly random texel positions and words
   task automatic random_texels(int count);
      logic [7:0] tx, ty;
      for (int i = 0; i < count; i++) begin
         tx = 8'($urandom);
         ty = 8'($urandom);
         send_texel(tx, ty, $urandom);
      end
   endtask

   function automatic spab_pkg::cfg_type random_brush();
      spab_pkg::cfg_type c;
      c.center_u = 18'($urandom_range(0, 65536));
      c.center_v = 18'($urandom_range(0, 65536));
      if ($urandom_range(0, 5) == 0) c.center_u = 18'($urandom);
      if ($urandom_range(0, 5) == 0) c.center_v = 18'($urandom);
      c.terrain_width = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(64, 8192));
      c.terrain_height = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(64, 8192));
      c.inner_radius = 16'($urandom_range(0, 2000));
      c.outer_radius = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 2000))
                       : c.inner_radius + 16'($urandom_range(1, 3000));
      c.brush_alpha = 8'($urandom);
      c.brush_mode = 3'($urandom);
      return c;
   endfunction

   task automatic test_reset_brush();
      send_texel(8'd0, 8'd0, 32'h0000_0000, 0);
      send_texel(8'd255, 8'd255, 32'hFFFF_FFFF, 0);
      send_texel(8'd2, 8'd1, 32'h1234_5678, 0);
      send_texel(8'd4, 8'd3, 32'hA5A5_5A5A, 0);
      send_texel(8'd8, 8'd0, 32'h00FF_00FF, 0);
      drain();
   endtask

   task automatic test_extremes();
      spab_pkg::cfg_type c;
      // every channel, paint and erase, ring and inner disc
      for (int m = 0; m < 8; m++) begin
         c = '{center_u: 18'sd32768, center_v: 18'sd32768, terrain_width: 16'd4096,
               terrain_height: 16'd4096, inner_radius: 16'd40, outer_radius: 16'd400,
               brush_alpha: (m[0] ? 8'd0 : 8'd200), brush_mode: 3'(m)};
         set_brush(c);
         send_texel(8'd128, 8'd128, 32'h8080_8080, 0);
         send_texel(8'd130, 8'd131, 32'h0000_0000, 0);
         send_texel(8'd140, 8'd128, 32'hFFFF_FFFF, 0);
         drain();
      end
      // outer below inner: no ring
      c.inner_radius = 16'd200;
      c.outer_radius = 16'd10;
      c.brush_mode = 3'd0;
      set_brush(c);
      send_texel(8'd128, 8'd135, 32'h1111_1111, 0);
      send_texel(8'd0, 8'd0, 32'h2222_2222, 0);
      drain();
      // field extremes: most negative and largest center, widest terrain
      c = '{center_u: -18'sd131072, center_v: 18'sd131071, terrain_width: 16'hFFFF,
            terrain_height: 16'hFFFF, inner_radius: 16'hFFFE, outer_radius: 16'hFFFF,
            brush_alpha: 8'd255, brush_mode: 3'd7};
      set_brush(c);
      send_texel(8'd255, 8'd0, 32'hFFFF_FFFF, 0);
      send_texel(8'd0, 8'd255, 32'h0000_0000, 0);
      drain();
      c.terrain_width = 16'd0;
      c.terrain_height = 16'd0;
      c.inner_radius = 16'd0;
      c.outer_radius = 16'd0;
      set_brush(c);
      send_texel(8'd77, 8'd199, 32'hDEAD_BEEF, 0);
      drain();
   endtask

   task automatic test_random_brushes();
      for (int p = 0; p < 26; p++) begin
         set_brush(random_brush());
         rsp_stall_off = (p % 5 == 4);
         random_texels(50);
         drain();
      end
      rsp_stall_off = 1'b0;
   endtask

   // results: random back-pressure unless rsp_stall_off is set, checked against the oldest expectation
   always @(posedge clock) begin
      texel_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            words_checked++;
            if (pending_texels.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word: data %h user %h", rsp_tdata, rsp_tuser);
            end else begin
               want = pending_texels.pop_front();
               if (rsp_tdata !== want.word || rsp_tuser[1:0] !== want.region ||
                   rsp_tuser[2] !== want.changed) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: word %h/%h region %0d/%0d changed %0d/%0d",
                              want.word, rsp_tdata, want.region, rsp_tuser[1:0],
                              want.changed, rsp_tuser[2]);
               end
            end
         end
         rsp_tready <= rsp_stall_off || ($urandom_range(0, 99) < 70) ||
                       ($urandom_range(0, 19) == 0);
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      brush = spab_pkg::CFG_RESET;
      @(posedge clock);
      test_reset_brush();
      test_extremes();
      test_random_brushes();
      if (pending_texels.size() != 0) mismatches++;
      $display("Sent %0d texel words over 38 brush settings, checked %0d results.",
               words_sent, words_checked);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("timeout");
      $display("Verification failed");
      $finish;
   end
endmodule
